// File: rtl/assert_macros.svh
// assertion macros shared by the gravity step engine rtl
// depends on nothing; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GPSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GPSE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPSE_ASSERT(label, clk, rst, prop, msg)
`define GPSE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/gpse_pkg.sv
// shared types, widths and codes for the gravity particle step engine
// no dependencies
package gpse_pkg;

  typedef struct packed {
    logic        [31:0] mass;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } particle_t;

  // arithmetic widths of the pair force path
  localparam int MAG_W  = 32;   // |dx| of two q16.16 positions
  localparam int R2_W   = 66;   // dx^2 + dy^2
  localparam int ROOT_W = 33;   // floor sqrt of r2
  localparam int DEN_W  = 99;   // r2 * r before the q alignment shift
  localparam int PROD_W = 129;  // g*m * |d| * dt
  localparam int MA_W   = 97;   // multiplicand width of the shared multiplier
  localparam int MB_W   = 33;   // multiplier width, one bit per cycle
  localparam int QW     = 31;   // saturated quotient width

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_STEP   = 3'd2;
  localparam logic [2:0] OP_DUMP   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [31:0] GRAV_RESET = 32'd1231190900;

endpackage

// File: rtl/gravity_particle_step_engine.sv
// 2d direct-sum gravity particle store: append, remove/find nearest, dump, time step
// holds the sequencer; uses gpse_pkg, gpse_store, gpse_mul, gpse_sqrt, gpse_div
//
// usage:
//   a transaction is taken when start is high and busy is low; operation and the
//   payload ports are sampled then. busy stays high until the operation completes.
//   each result appears on the result ports for one cycle with done high; last marks
//   the final one. the receiver cannot stall, so results are never held back.
//   gravity_constant is written over cfg_valid/cfg_ready/cfg_data while idle.
// per operation:
//   append and unused codes give a single result. dump reads and emits each particle
//   in turn. find and remove compute the squared distance to every particle held;
//   remove then moves each later entry down one place. time step visits every
//   source-target pair with a massive source, skips pairs at the same position,
//   then updates the position of every particle.
//   the pair cost is set by the shared bit-serial multiplier (seven products), the
//   root unit and the divider (two quotients), each one bit per cycle.
// reset clears the particle count and loads the default constant; store contents
// are not cleared and entries past the count are never read.
`include "assert_macros.svh"
module gravity_particle_step_engine #(
  parameter int MAX_PARTICLES = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [31:0]        mass,
  input  logic [31:0]        time_step,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [5:0]         index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic [31:0]        out_mass,
  output logic [6:0]         count,
  output logic               last
);
  import gpse_pkg::*;

  localparam int IW   = $clog2(MAX_PARTICLES);
  localparam int CNTW = $clog2(MAX_PARTICLES + 1);
  localparam int DSH  = 64 - 2 * FRACTION_BITS;
  localparam int DW   = DEN_W + DSH;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_DUMP_RD   = 5'd2;
  localparam logic [4:0] S_DUMP_EMIT = 5'd3;
  localparam logic [4:0] S_F_RD      = 5'd4;
  localparam logic [4:0] S_F_LD      = 5'd5;
  localparam logic [4:0] S_F_SQA     = 5'd6;
  localparam logic [4:0] S_F_SQB     = 5'd7;
  localparam logic [4:0] S_NEAR_RD   = 5'd8;
  localparam logic [4:0] S_NEAR_EMIT = 5'd9;
  localparam logic [4:0] S_SH_CHK    = 5'd10;
  localparam logic [4:0] S_SH_WR     = 5'd11;
  localparam logic [4:0] S_SRC_RD    = 5'd12;
  localparam logic [4:0] S_SRC_LD    = 5'd13;
  localparam logic [4:0] S_SRC_NEXT  = 5'd14;
  localparam logic [4:0] S_T_RD      = 5'd15;
  localparam logic [4:0] S_T_LD      = 5'd16;
  localparam logic [4:0] S_R2A       = 5'd17;
  localparam logic [4:0] S_R2B       = 5'd18;
  localparam logic [4:0] S_SQRT      = 5'd19;
  localparam logic [4:0] S_DEN       = 5'd20;
  localparam logic [4:0] S_NUM1      = 5'd21;
  localparam logic [4:0] S_NUM2      = 5'd22;
  localparam logic [4:0] S_DIV       = 5'd23;
  localparam logic [4:0] S_T_WR      = 5'd24;
  localparam logic [4:0] S_T_NEXT    = 5'd25;
  localparam logic [4:0] S_P_RD      = 5'd26;
  localparam logic [4:0] S_P_LD      = 5'd27;
  localparam logic [4:0] S_P_ADD     = 5'd28;

  function automatic logic [31:0] magdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic [32:0] d;
    logic [32:0] nd;
    d  = {a[31], a} - {b[31], b};
    nd = -d;
    return d[32] ? nd[31:0] : d[31:0];
  endfunction

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    logic [31:0] nv;
    nv = -v;
    return v[31] ? nv : v;
  endfunction

  function automatic logic signed [31:0] vadd(input logic signed [31:0] v,
                                              input logic neg,
                                              input logic [QW-1:0] qv);
    logic [32:0] s;
    s = {v[31], v} + (neg ? -{2'b00, qv} : {2'b00, qv});
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] padd(input logic signed [31:0] p,
                                              input logic neg,
                                              input logic [63:0] m);
    logic [63:0] st;
    logic [65:0] s;
    st = m >> FRACTION_BITS;
    s  = {{34{p[31]}}, p} + (neg ? -{2'b00, st} : {2'b00, st});
    if (s[65:31] != {35{s[65]}}) begin
      return s[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  logic [4:0]        state;
  logic [CNTW-1:0]   pcount;
  logic [31:0]       gconst;
  logic [2:0]        op;
  particle_t         ient;
  logic [31:0]       dt;
  logic [IW-1:0]     src;
  logic [IW-1:0]     tgt;
  logic [IW-1:0]     best;
  logic [R2_W-1:0]   bestd;
  logic signed [31:0] spx;
  logic signed [31:0] spy;
  logic [63:0]       k;
  particle_t         ent;
  logic              sgnx;
  logic              sgny;
  logic [MAG_W-1:0]  mx;
  logic [MAG_W-1:0]  my;
  logic [R2_W-1:0]   r2;
  logic [DEN_W-1:0]  den;
  logic              axis;
  logic [63:0]       prx;
  logic [63:0]       pry;

  logic              mul_go;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_c;
  logic              mul_done;
  logic [PROD_W-1:0] mul_p;
  logic              sq_go;
  logic [R2_W-1:0]   sq_x;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_go;
  logic [PROD_W-1:0] dv_n;
  logic [DW-1:0]     dv_d;
  logic              dv_done;
  logic [QW-1:0]     dv_q;

  logic              mem_we;
  logic [IW-1:0]     waddr;
  particle_t         wdata;
  logic [IW-1:0]     raddr;
  particle_t         rdata;

  logic              full;
  logic              empty;
  logic              tgt_last;
  logic              src_last;
  logic [32:0]       ddx;
  logic [32:0]       ddy;

  logic              em;
  logic [1:0]        em_status;
  logic [IW-1:0]     em_idx;
  particle_t         em_ent;
  logic [CNTW-1:0]   em_cnt;
  logic              em_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign full      = (pcount == CNTW'(MAX_PARTICLES));
  assign empty     = (pcount == '0);
  assign tgt_last  = ((CNTW'(tgt) + CNTW'(1)) == pcount);
  assign src_last  = ((CNTW'(src) + CNTW'(1)) == pcount);
  // source minus target, sign gives the pull direction
  assign ddx       = {spx[31], spx} - {rdata.pos_x[31], rdata.pos_x};
  assign ddy       = {spy[31], spy} - {rdata.pos_y[31], rdata.pos_y};

  gpse_store #(.DEPTH(MAX_PARTICLES), .AW(IW)) u_store (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  gpse_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b), .c(mul_c),
    .done(mul_done), .p(mul_p)
  );

  gpse_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go), .x(sq_x), .done(sq_done), .root(sq_root)
  );

  gpse_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_go), .n(dv_n), .d(dv_d), .done(dv_done), .q(dv_q)
  );

  always_comb begin
    case (state)
      S_SRC_RD:  raddr = src;
      S_NEAR_RD: raddr = best;
      S_SH_CHK:  raddr = tgt + IW'(1);
      default:   raddr = tgt;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = tgt;
    wdata  = ent;
    case (state)
      S_DECODE: begin
        if (op == OP_APPEND && !full) begin
          mem_we = 1'b1;
          waddr  = IW'(pcount);
          wdata  = ient;
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        wdata  = rdata;
      end
      S_T_WR: mem_we = 1'b1;
      S_P_ADD: begin
        mem_we      = 1'b1;
        wdata.pos_x = padd(ent.pos_x, ent.vel_x[31], prx);
        wdata.pos_y = padd(ent.pos_y, ent.vel_y[31], pry);
      end
      default: ;
    endcase
  end

  always_comb begin
    em        = 1'b0;
    em_status = ST_OK;
    em_idx    = '0;
    em_ent    = '0;
    em_cnt    = pcount;
    em_last   = 1'b1;
    case (state)
      S_DECODE: begin
        case (op)
          OP_APPEND: begin
            em = 1'b1;
            if (full) begin
              em_status = ST_FULL;
            end else begin
              em_idx = IW'(pcount);
              em_ent = ient;
              em_cnt = pcount + CNTW'(1);
            end
          end
          OP_STEP: em = empty;
          OP_REMOVE, OP_DUMP, OP_FIND: begin
            if (empty) begin
              em        = 1'b1;
              em_status = ST_EMPTY;
            end
          end
          default: em = 1'b1;
        endcase
      end
      S_DUMP_EMIT: begin
        em      = 1'b1;
        em_idx  = tgt;
        em_ent  = rdata;
        em_last = tgt_last;
      end
      S_NEAR_EMIT: begin
        em     = 1'b1;
        em_idx = best;
        em_ent = rdata;
        if (op == OP_REMOVE) begin
          em_cnt = pcount - CNTW'(1);
        end
      end
      S_P_ADD: em = tgt_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      done <= 1'b0;
    end else if (em) begin
      done      <= 1'b1;
      status    <= em_status;
      index     <= 6'(em_idx);
      out_pos_x <= em_ent.pos_x;
      out_pos_y <= em_ent.pos_y;
      out_vel_x <= em_ent.vel_x;
      out_vel_y <= em_ent.vel_y;
      out_mass  <= em_ent.mass;
      count     <= 7'(em_cnt);
      last      <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    mul_go <= 1'b0;
    sq_go  <= 1'b0;
    dv_go  <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      pcount <= '0;
      gconst <= GRAV_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gconst <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op         <= operation;
            ient.pos_x <= pos_x;
            ient.pos_y <= pos_y;
            ient.vel_x <= vel_x;
            ient.vel_y <= vel_y;
            ient.mass  <= mass;
            dt         <= time_step;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          tgt <= '0;
          src <= '0;
          case (op)
            OP_APPEND: begin
              if (!full) begin
                pcount <= pcount + CNTW'(1);
              end
              state <= S_IDLE;
            end
            OP_STEP:           state <= empty ? S_IDLE : S_SRC_RD;
            OP_DUMP:           state <= empty ? S_IDLE : S_DUMP_RD;
            OP_REMOVE, OP_FIND: state <= empty ? S_IDLE : S_F_RD;
            default:           state <= S_IDLE;
          endcase
        end
        S_DUMP_RD: state <= S_DUMP_EMIT;
        S_DUMP_EMIT: begin
          if (tgt_last) begin
            state <= S_IDLE;
          end else begin
            tgt   <= tgt + IW'(1);
            state <= S_DUMP_RD;
          end
        end
        S_F_RD: state <= S_F_LD;
        S_F_LD: begin
          mx     <= magdiff(rdata.pos_x, ient.pos_x);
          my     <= magdiff(rdata.pos_y, ient.pos_y);
          mul_go <= 1'b1;
          mul_a  <= MA_W'(magdiff(rdata.pos_x, ient.pos_x));
          mul_b  <= MB_W'(magdiff(rdata.pos_x, ient.pos_x));
          mul_c  <= '0;
          state  <= S_F_SQA;
        end
        S_F_SQA: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            mul_a  <= MA_W'(my);
            mul_b  <= MB_W'(my);
            mul_c  <= mul_p;
            state  <= S_F_SQB;
          end
        end
        S_F_SQB: begin
          if (mul_done) begin
            // strict less-than keeps the lowest index on ties
            if (tgt == '0 || mul_p[R2_W-1:0] < bestd) begin
              best  <= tgt;
              bestd <= mul_p[R2_W-1:0];
            end
            if (tgt_last) begin
              state <= S_NEAR_RD;
            end else begin
              tgt   <= tgt + IW'(1);
              state <= S_F_RD;
            end
          end
        end
        S_NEAR_RD: state <= S_NEAR_EMIT;
        S_NEAR_EMIT: begin
          if (op == OP_REMOVE) begin
            tgt   <= best;
            state <= S_SH_CHK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SH_CHK: begin
          if (tgt_last) begin
            pcount <= pcount - CNTW'(1);
            state  <= S_IDLE;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          tgt   <= tgt + IW'(1);
          state <= S_SH_CHK;
        end
        S_SRC_RD: state <= S_SRC_LD;
        S_SRC_LD: begin
          spx <= rdata.pos_x;
          spy <= rdata.pos_y;
          k   <= gconst * rdata.mass;
          tgt <= '0;
          state <= (rdata.mass == '0) ? S_SRC_NEXT : S_T_RD;
        end
        S_SRC_NEXT: begin
          if (src_last) begin
            tgt   <= '0;
            state <= S_P_RD;
          end else begin
            src   <= src + IW'(1);
            state <= S_SRC_RD;
          end
        end
        S_T_RD: state <= S_T_LD;
        S_T_LD: begin
          ent  <= rdata;
          sgnx <= ddx[32];
          sgny <= ddy[32];
          mx   <= magdiff(spx, rdata.pos_x);
          my   <= magdiff(spy, rdata.pos_y);
          if (ddx == '0 && ddy == '0) begin
            state <= S_T_NEXT;
          end else begin
            mul_go <= 1'b1;
            mul_a  <= MA_W'(magdiff(spx, rdata.pos_x));
            mul_b  <= MB_W'(magdiff(spx, rdata.pos_x));
            mul_c  <= '0;
            state  <= S_R2A;
          end
        end
        S_R2A: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            mul_a  <= MA_W'(my);
            mul_b  <= MB_W'(my);
            mul_c  <= mul_p;
            state  <= S_R2B;
          end
        end
        S_R2B: begin
          if (mul_done) begin
            r2    <= mul_p[R2_W-1:0];
            sq_go <= 1'b1;
            sq_x  <= mul_p[R2_W-1:0];
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            mul_go <= 1'b1;
            mul_a  <= MA_W'(r2);
            mul_b  <= MB_W'(sq_root);
            mul_c  <= '0;
            state  <= S_DEN;
          end
        end
        S_DEN: begin
          if (mul_done) begin
            den    <= mul_p[DEN_W-1:0];
            axis   <= 1'b0;
            mul_go <= 1'b1;
            mul_a  <= MA_W'(k);
            mul_b  <= MB_W'(mx);
            mul_c  <= '0;
            state  <= S_NUM1;
          end
        end
        S_NUM1: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            mul_a  <= mul_p[MA_W-1:0];
            mul_b  <= MB_W'(dt);
            mul_c  <= '0;
            state  <= S_NUM2;
          end
        end
        S_NUM2: begin
          if (mul_done) begin
            dv_go <= 1'b1;
            dv_n  <= mul_p;
            // align r2*r with the 64 fraction bits of the constant
            dv_d  <= {den, {DSH{1'b0}}};
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            if (!axis) begin
              ent.vel_x <= vadd(ent.vel_x, sgnx, dv_q);
              axis      <= 1'b1;
              mul_go    <= 1'b1;
              mul_a     <= MA_W'(k);
              mul_b     <= MB_W'(my);
              mul_c     <= '0;
              state     <= S_NUM1;
            end else begin
              ent.vel_y <= vadd(ent.vel_y, sgny, dv_q);
              state     <= S_T_WR;
            end
          end
        end
        S_T_WR: state <= S_T_NEXT;
        S_T_NEXT: begin
          if (tgt_last) begin
            state <= S_SRC_NEXT;
          end else begin
            tgt   <= tgt + IW'(1);
            state <= S_T_RD;
          end
        end
        S_P_RD: state <= S_P_LD;
        S_P_LD: begin
          ent   <= rdata;
          prx   <= absv(rdata.vel_x) * dt;
          pry   <= absv(rdata.vel_y) * dt;
          state <= S_P_ADD;
        end
        S_P_ADD: begin
          if (tgt_last) begin
            state <= S_IDLE;
          end else begin
            tgt   <= tgt + IW'(1);
            state <= S_P_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GPSE_ASSERT(a_done_follows_busy, clk, rst, done |-> $past(busy), "result outside a transaction")
  `GPSE_ASSERT(a_count_bound, clk, rst, pcount <= CNTW'(MAX_PARTICLES), "particle count overflow")
  `GPSE_ASSERT(a_accept_busy, clk, rst, start && !busy |=> busy, "accepted transaction not started")
  `GPSE_ASSERT(a_write_busy, clk, rst, mem_we |-> busy, "store written while idle")
  `GPSE_ASSERT(a_more_follows, clk, rst, done && !last |-> busy, "dump ended before last item")
  `GPSE_ASSERT_NR(a_reset_quiet, clk, rst |=> !busy && !done, "not idle after reset")

endmodule

// File: rtl/gpse_store.sv
// particle store: one synchronous ram, one write and one read port
// read data is registered; uses gpse_pkg
module gpse_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  gpse_pkg::particle_t   wdata,
  input  logic [AW-1:0]         raddr,
  output gpse_pkg::particle_t   rdata
);
  import gpse_pkg::*;

  particle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gpse_mul.sv
// shared shift-add multiplier with an initial addend, one multiplier bit per cycle
// uses gpse_pkg widths
module gpse_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gpse_pkg::MA_W-1:0]   a,
  input  logic [gpse_pkg::MB_W-1:0]   b,
  input  logic [gpse_pkg::PROD_W-1:0] c,
  output logic                        done,
  output logic [gpse_pkg::PROD_W-1:0] p
);
  import gpse_pkg::*;

  localparam int CW = $clog2(MB_W + 1);

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] ash;
  logic [MB_W-1:0]   bsh;
  logic [CW-1:0]     cnt;
  logic              run;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      acc <= c;
      ash <= PROD_W'(a);
      bsh <= b;
      cnt <= CW'(MB_W);
      run <= 1'b1;
    end else if (run) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign p = acc;

endmodule

// File: rtl/gpse_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
// uses gpse_pkg widths
module gpse_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gpse_pkg::R2_W-1:0]   x,
  output logic                        done,
  output logic [gpse_pkg::ROOT_W-1:0] root
);
  import gpse_pkg::*;

  localparam int RMW = ROOT_W + 3;
  localparam int CW  = $clog2(ROOT_W + 1);

  logic [R2_W-1:0]  xs;
  logic [RMW-1:0]   rem;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [RMW-1:0]   rem_sh;
  logic [RMW-1:0]   trial;

  assign rem_sh = {rem[ROOT_W:0], xs[R2_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(ROOT_W);
      run  <= 1'b1;
    end else if (run) begin
      xs <= xs << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/gpse_div.sv
// restoring divider giving a quotient saturated to 31 bits, one bit per cycle
// uses gpse_pkg widths
module gpse_div #(
  parameter int DW = 131
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gpse_pkg::PROD_W-1:0] n,
  input  logic [DW-1:0]               d,
  output logic                        done,
  output logic [gpse_pkg::QW-1:0]     q
);
  import gpse_pkg::*;

  localparam int CW  = DW + QW;
  localparam int NQ  = QW + 1;
  localparam int KW  = $clog2(NQ + 1);

  logic [CW-1:0] rem;
  logic [CW-1:0] ds;
  logic [NQ-1:0] qr;
  logic [KW-1:0] cnt;
  logic          run;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      rem <= CW'(n);
      ds  <= {d, {QW{1'b0}}};
      qr  <= '0;
      cnt <= KW'(NQ);
      run <= 1'b1;
    end else if (run) begin
      if (rem >= ds) begin
        rem <= rem - ds;
        qr  <= {qr[NQ-2:0], 1'b1};
      end else begin
        qr  <= {qr[NQ-2:0], 1'b0};
      end
      ds  <= ds >> 1;
      cnt <= cnt - KW'(1);
      if (cnt == KW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // top quotient bit set means the true quotient is at least 2^31
  assign q = qr[NQ-1] ? {QW{1'b1}} : qr[QW-1:0];

endmodule
